[rtl/core/mpsu_pkg.sv]
`default_nettype none
package mpsu_pkg;

  // lattice and table sizes
  localparam int MAX_SITES         = 128;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int ADDR_W            = $clog2(MAX_SITES);
  localparam int N_W               = $clog2(MAX_SITES + 1);
  localparam int CMP_W             = (N_W > 8) ? N_W : 8;
  localparam int IDX_W             = $clog2(EXP_TABLE_ENTRIES);
  localparam int IDXP_W            = 28 + IDX_W + 1;

  // item actions (code 3 behaves as a read)
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SITE_COUNT = 3'd0;
  localparam logic [2:0] CFG_SPACING    = 3'd1;
  localparam logic [2:0] CFG_HALF_INV   = 3'd2;
  localparam logic [2:0] CFG_QUARTIC    = 3'd3;
  localparam logic [2:0] CFG_PROP_WIDTH = 3'd4;

  // configuration reset values
  localparam logic [7:0]  RST_SITE_COUNT = 8'd100;
  localparam logic [31:0] RST_SPACING    = 32'd1677722;
  localparam logic [31:0] RST_HALF_INV   = 32'd83886080;
  localparam logic [31:0] RST_QUARTIC    = 32'd0;
  localparam logic [31:0] RST_PROP_WIDTH = 32'd12582912;

  // RAM read address select
  localparam logic [1:0] RD_SITE  = 2'd0;
  localparam logic [1:0] RD_LEFT  = 2'd1;
  localparam logic [1:0] RD_RIGHT = 2'd2;

  // multiply sequence, in issue order
  localparam logic [2:0] OP_M1  = 3'd0;  // 2d * (xp + x0 - xl - xr)
  localparam logic [2:0] OP_KIN = 3'd1;  // half_inv * m1
  localparam logic [2:0] OP_P2  = 3'd2;  // d * (xp + x0)
  localparam logic [2:0] OP_Q1  = 3'd3;  // xp * xp
  localparam logic [2:0] OP_Q2  = 3'd4;  // x0 * x0
  localparam logic [2:0] OP_P4  = 3'd5;  // p2 * (q1 + q2)
  localparam logic [2:0] OP_T   = 3'd6;  // quartic * p4
  localparam logic [2:0] OP_POT = 3'd7;  // spacing * (p2/2 + t)

  // saturation limit of products and sums
  localparam logic signed [63:0] SAT_LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

  // controller to datapath commands
  typedef struct packed {
    logic       take_item;
    logic [1:0] rd_sel;
    logic       res_zero;
    logic       res_load;
    logic       res_read;
    logic       cap_x0;
    logic       cap_xl;
    logic       cap_xr;
    logic       calc_xp;
    logic       calc_sums;
    logic       mul_start;
    logic       mul_cap;
    logic [2:0] mul_op;
    logic       calc_ds;
    logic       calc_idx;
    logic       commit;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       in_range;
    logic [1:0] action;
    logic       mul_done;
  } dp_stat_t;

  typedef logic [16:0] exp_tab_t [EXP_TABLE_ENTRIES];

  // series terms of exp(-h) in Q0.32, h = 16/E, each term floored
  localparam logic [127:0] EXP_H   = (128'd16 << 32) / EXP_TABLE_ENTRIES;
  localparam logic [127:0] EXP_T1  = EXP_H;
  localparam logic [127:0] EXP_T2  = ((EXP_T1 * EXP_H) >> 32) / 2;
  localparam logic [127:0] EXP_T3  = ((EXP_T2 * EXP_H) >> 32) / 3;
  localparam logic [127:0] EXP_T4  = ((EXP_T3 * EXP_H) >> 32) / 4;
  localparam logic [127:0] EXP_T5  = ((EXP_T4 * EXP_H) >> 32) / 5;
  localparam logic [127:0] EXP_T6  = ((EXP_T5 * EXP_H) >> 32) / 6;
  localparam logic [127:0] EXP_T7  = ((EXP_T6 * EXP_H) >> 32) / 7;
  localparam logic [127:0] EXP_T8  = ((EXP_T7 * EXP_H) >> 32) / 8;
  localparam logic [127:0] EXP_T9  = ((EXP_T8 * EXP_H) >> 32) / 9;
  localparam logic [127:0] EXP_T10 = ((EXP_T9 * EXP_H) >> 32) / 10;
  localparam logic [127:0] EXP_T11 = ((EXP_T10 * EXP_H) >> 32) / 11;
  localparam logic [127:0] EXP_T12 = ((EXP_T11 * EXP_H) >> 32) / 12;
  localparam logic [127:0] EXP_T13 = ((EXP_T12 * EXP_H) >> 32) / 13;
  localparam logic [127:0] EXP_T14 = ((EXP_T13 * EXP_H) >> 32) / 14;
  localparam logic [127:0] EXP_T15 = ((EXP_T14 * EXP_H) >> 32) / 15;
  localparam logic [127:0] EXP_T16 = ((EXP_T15 * EXP_H) >> 32) / 16;
  // step ratio exp(-h), alternating sum of the terms
  localparam logic [127:0] EXP_R = (128'd1 << 32) - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                   - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                   + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13
                                   + EXP_T14 - EXP_T15 + EXP_T16;

  function automatic logic signed [63:0] clamp62(input logic signed [63:0] v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd62(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] ca;
    logic signed [63:0] cb;
    logic signed [64:0] s;
    ca = clamp62(a);
    cb = clamp62(b);
    s  = {ca[63], ca} + {cb[63], cb};
    if (s > SAT_LIM65) return SAT_LIM;
    if (s < -SAT_LIM65) return -SAT_LIM;
    return s[63:0];
  endfunction

  // exp(-16k/E) table in Q1.16, repeated products of one step ratio
  function automatic exp_tab_t build_exp_table();
    exp_tab_t     tab;
    logic [127:0] v;
    v = 128'd1 << 32;
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      tab[k] = 17'((v + 128'h8000) >> 16);
      v = (v * EXP_R + 128'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

[rtl/core/mpsu_in_if.sv]
`default_nettype none
interface mpsu_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [6:0]  site;
  logic signed [31:0] load_value;
  logic signed [15:0] proposal_noise;
  logic        [15:0] accept_noise;

  modport source (output valid, action, site, load_value, proposal_noise, accept_noise,
                  input ready);
  modport sink (input valid, action, site, load_value, proposal_noise, accept_noise,
                output ready);
endinterface
`default_nettype wire

[rtl/core/mpsu_out_if.sv]
`default_nettype none
interface mpsu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] site_value;
  logic               accepted;
  logic        [7:0]  accept_count;

  modport source (output valid, site_value, accepted, accept_count, input ready);
  modport sink (input valid, site_value, accepted, accept_count, output ready);
endinterface
`default_nettype wire

[rtl/core/mpsu_ram.sv]
`default_nettype none
module mpsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/mpsu_mul.sv]
`default_nettype none
module mpsu_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      p
);

  logic               busy_r, busy_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic               neg_r;
  logic [61:0]        ua_r, ub_r;
  logic [127:0]       acc_r, acc_nxt;
  logic signed [63:0] p_r, p_nxt;
  logic signed [63:0] ca, cb;
  logic [31:0]        al, bl;
  logic [63:0]        pp;
  logic [127:0]       pp_ext;
  logic signed [63:0] r64;

  // clamp the operands; their magnitudes are registered on start
  always_comb begin
    ca = mpsu_pkg::clamp62(a);
    cb = mpsu_pkg::clamp62(b);
  end

  // one 32x32 partial product per cycle, limb pair chosen by the count
  always_comb begin
    al = cnt_r[1] ? {2'b00, ua_r[61:32]} : ua_r[31:0];
    bl = cnt_r[0] ? {2'b00, ub_r[61:32]} : ub_r[31:0];
    pp = al * bl;
    case ({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]})
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      2'd2:    pp_ext = {pp, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // Q.24 truncation with saturation
  always_comb begin
    if (acc_r[127:86] != '0) r64 = mpsu_pkg::SAT_LIM;
    else r64 = {2'b00, acc_r[85:24]};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r && !cnt_r[2]) begin
      acc_nxt = acc_r + pp_ext;
      cnt_nxt = cnt_r + 3'd1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
      p_nxt    = neg_r ? -r64 : r64;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= (a < 0) != (b < 0);
      ua_r  <= ca[63] ? 62'(-ca) : ca[61:0];
      ub_r  <= cb[63] ? 62'(-cb) : cb[61:0];
    end
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule
`default_nettype wire

[rtl/core/mpsu_datapath.sv]
`default_nettype none
module mpsu_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mpsu_pkg::dp_cmd_t      cmd,
  output mpsu_pkg::dp_stat_t          stat,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic [1:0]             in_action,
  input  wire logic [6:0]             in_site,
  input  wire logic signed [31:0]     in_load_value,
  input  wire logic signed [15:0]     in_proposal_noise,
  input  wire logic [15:0]            in_accept_noise,
  output logic signed [31:0]          out_site_value,
  output logic                        out_accepted,
  output logic [7:0]                  out_accept_count
);

  localparam int AW       = mpsu_pkg::ADDR_W;
  localparam int CW       = mpsu_pkg::CMP_W;
  localparam int IDXP_LOC = mpsu_pkg::IDXP_W;

  // configuration
  logic [7:0]  site_count_r;
  logic [31:0] spacing_r, half_inv_r, quartic_r, prop_width_r;

  // latched item
  logic [1:0]         act_r;
  logic [6:0]         site_r;
  logic signed [31:0] load_r;
  logic signed [15:0] pnoise_r;
  logic [15:0]        anoise_r;

  // working values
  logic signed [33:0] step_r;
  logic signed [31:0] x0_r, xl_r, xr_r, xp_r;
  logic signed [32:0] d_r, sp_r;
  logic signed [33:0] s1_r;
  logic signed [63:0] m1_r, kin_r, p2_r, p2h_r, q1_r, qs_r, p4_r, ps_r, pot_r, ds_r;
  logic               le0_r, lt16_r;
  logic [16:0]        tab_r;
  logic [7:0]         cnt_r, cnt_nxt;
  logic signed [31:0] res_value_r;
  logic               res_acc_r;
  logic signed [31:0] out_value_r;
  logic               out_acc_r;
  logic [7:0]         out_cnt_r;

  logic [CW-1:0]      n_c, sc_ext, site_ext;
  logic [AW-1:0]      site_a, left_a, right_a, raddr;
  logic signed [48:0] prod_c;
  logic signed [34:0] xsum_c;
  logic signed [31:0] xp_c;
  logic signed [33:0] x0e, xle, xre, xpe;
  logic signed [63:0] ma, mb, mp;
  logic               mdone;
  logic [IDXP_LOC-1:0] idxp_c;
  logic [mpsu_pkg::IDX_W-1:0] idx_c;
  logic               acc_c;
  logic               ram_we;
  logic [31:0]        ram_wdata, ram_rdata;
  logic signed [63:0] p2h_c;

  // sites in use, clamped to the supported range
  always_comb begin
    sc_ext   = CW'(site_count_r);
    site_ext = CW'(site_r);
    if (sc_ext < CW'(2)) n_c = CW'(2);
    else if (sc_ext > CW'(mpsu_pkg::MAX_SITES)) n_c = CW'(mpsu_pkg::MAX_SITES);
    else n_c = sc_ext;
  end

  // periodic neighbor addresses
  always_comb begin
    site_a  = AW'(site_r);
    left_a  = (site_r == 7'd0) ? AW'(n_c - CW'(1)) : AW'(site_ext - CW'(1));
    right_a = ((site_ext + CW'(1)) == n_c) ? '0 : AW'(site_ext + CW'(1));
    case (cmd.rd_sel)
      mpsu_pkg::RD_LEFT:  raddr = left_a;
      mpsu_pkg::RD_RIGHT: raddr = right_a;
      default:            raddr = site_a;
    endcase
  end

  assign stat.in_range = site_ext < n_c;
  assign stat.action   = act_r;
  assign stat.mul_done = mdone;

  // proposal step, floored
  assign prod_c = $signed(pnoise_r) * $signed({1'b0, prop_width_r});

  // proposed value, saturated to 32 bits
  always_comb begin
    xsum_c = {{3{x0_r[31]}}, x0_r} + {step_r[33], step_r};
    if (xsum_c[34:31] == 4'b0000 || xsum_c[34:31] == 4'b1111) xp_c = xsum_c[31:0];
    else if (xsum_c[34]) xp_c = 32'sh8000_0000;
    else xp_c = 32'sh7FFF_FFFF;
  end

  assign x0e = {{2{x0_r[31]}}, x0_r};
  assign xle = {{2{xl_r[31]}}, xl_r};
  assign xre = {{2{xr_r[31]}}, xr_r};
  assign xpe = {{2{xp_r[31]}}, xp_r};

  // multiplier operands by sequence step
  always_comb begin
    case (cmd.mul_op)
      mpsu_pkg::OP_M1: begin
        ma = {{30{d_r[32]}}, d_r, 1'b0};
        mb = {{30{s1_r[33]}}, s1_r};
      end
      mpsu_pkg::OP_KIN: begin
        ma = {32'd0, half_inv_r};
        mb = m1_r;
      end
      mpsu_pkg::OP_P2: begin
        ma = {{31{d_r[32]}}, d_r};
        mb = {{31{sp_r[32]}}, sp_r};
      end
      mpsu_pkg::OP_Q1: begin
        ma = {{32{xp_r[31]}}, xp_r};
        mb = {{32{xp_r[31]}}, xp_r};
      end
      mpsu_pkg::OP_Q2: begin
        ma = {{32{x0_r[31]}}, x0_r};
        mb = {{32{x0_r[31]}}, x0_r};
      end
      mpsu_pkg::OP_P4: begin
        ma = p2_r;
        mb = qs_r;
      end
      mpsu_pkg::OP_T: begin
        ma = {32'd0, quartic_r};
        mb = p4_r;
      end
      default: begin
        ma = {32'd0, spacing_r};
        mb = ps_r;
      end
    endcase
  end

  mpsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .p     (mp)
  );

  // half of p2, rounded toward zero
  assign p2h_c = (mp + $signed({63'd0, mp[63]})) >>> 1;

  // exp table index from the action change
  assign idxp_c = IDXP_LOC'(ds_r[27:0]) * IDXP_LOC'(mpsu_pkg::EXP_TABLE_ENTRIES);
  assign idx_c  = idxp_c[28 +: mpsu_pkg::IDX_W];

  // accept decision and counter update
  always_comb begin
    acc_c   = le0_r || (lt16_r && ({1'b0, anoise_r} < tab_r));
    cnt_nxt = (site_r == 7'd0) ? 8'd0 : cnt_r;
    if (acc_c && cnt_nxt != 8'hFF) cnt_nxt = cnt_nxt + 8'd1;
  end

  // path store
  assign ram_we    = cmd.res_load || (cmd.commit && acc_c);
  assign ram_wdata = cmd.res_load ? load_r : xp_r;

  mpsu_ram #(
    .WIDTH (32),
    .DEPTH (mpsu_pkg::MAX_SITES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (site_a),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // configuration registers and acceptance counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r <= mpsu_pkg::RST_SITE_COUNT;
      spacing_r    <= mpsu_pkg::RST_SPACING;
      half_inv_r   <= mpsu_pkg::RST_HALF_INV;
      quartic_r    <= mpsu_pkg::RST_QUARTIC;
      prop_width_r <= mpsu_pkg::RST_PROP_WIDTH;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mpsu_pkg::CFG_SITE_COUNT: site_count_r <= cfg_data[7:0];
          mpsu_pkg::CFG_SPACING:    spacing_r    <= cfg_data;
          mpsu_pkg::CFG_HALF_INV:   half_inv_r   <= cfg_data;
          mpsu_pkg::CFG_QUARTIC:    quartic_r    <= cfg_data;
          mpsu_pkg::CFG_PROP_WIDTH: prop_width_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) cnt_r <= cnt_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      act_r    <= in_action;
      site_r   <= in_site;
      load_r   <= in_load_value;
      pnoise_r <= in_proposal_noise;
      anoise_r <= in_accept_noise;
    end
    step_r <= prod_c[48:15];
    if (cmd.cap_x0) x0_r <= ram_rdata;
    if (cmd.cap_xl) xl_r <= ram_rdata;
    if (cmd.cap_xr) xr_r <= ram_rdata;
    if (cmd.calc_xp) xp_r <= xp_c;
    if (cmd.calc_sums) begin
      d_r  <= 33'(xpe - x0e);
      sp_r <= 33'(xpe + x0e);
      s1_r <= xpe + x0e - xle - xre;
    end
    if (cmd.mul_cap) begin
      case (cmd.mul_op)
        mpsu_pkg::OP_M1:  m1_r <= mp;
        mpsu_pkg::OP_KIN: kin_r <= mp;
        mpsu_pkg::OP_P2: begin
          p2_r  <= mp;
          p2h_r <= p2h_c;
        end
        mpsu_pkg::OP_Q1:  q1_r <= mp;
        mpsu_pkg::OP_Q2:  qs_r <= mpsu_pkg::sadd62(q1_r, mp);
        mpsu_pkg::OP_P4:  p4_r <= mp;
        mpsu_pkg::OP_T:   ps_r <= mpsu_pkg::sadd62(p2h_r, mp);
        default:          pot_r <= mp;
      endcase
    end
    if (cmd.calc_ds) ds_r <= mpsu_pkg::sadd62(kin_r, pot_r);
    if (cmd.calc_idx) begin
      le0_r  <= (ds_r <= 64'sd0);
      lt16_r <= (ds_r < 64'sd268435456);
      tab_r  <= mpsu_pkg::EXP_TABLE[idx_c];
    end
    // result of the item
    if (cmd.res_zero) begin
      res_value_r <= '0;
      res_acc_r   <= 1'b0;
    end
    if (cmd.res_load) begin
      res_value_r <= load_r;
      res_acc_r   <= 1'b0;
    end
    if (cmd.res_read) begin
      res_value_r <= ram_rdata;
      res_acc_r   <= 1'b0;
    end
    if (cmd.commit) begin
      res_value_r <= acc_c ? xp_r : x0_r;
      res_acc_r   <= acc_c;
    end
    // output register
    if (cmd.out_load) begin
      out_value_r <= res_value_r;
      out_acc_r   <= res_acc_r;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_site_value   = out_value_r;
  assign out_accepted     = out_acc_r;
  assign out_accept_count = out_cnt_r;

endmodule
`default_nettype wire

[rtl/core/mpsu_ctrl.sv]
`default_nettype none
module mpsu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mpsu_pkg::dp_stat_t stat,
  output mpsu_pkg::dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDW    = 4'd2;
  localparam logic [3:0] S_RD1    = 4'd3;
  localparam logic [3:0] S_RD2    = 4'd4;
  localparam logic [3:0] S_RD3    = 4'd5;
  localparam logic [3:0] S_PREP   = 4'd6;
  localparam logic [3:0] S_MSTART = 4'd7;
  localparam logic [3:0] S_MWAIT  = 4'd8;
  localparam logic [3:0] S_DS     = 4'd9;
  localparam logic [3:0] S_IDX    = 4'd10;
  localparam logic [3:0] S_COMMIT = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd        = '0;
    cmd.rd_sel = mpsu_pkg::RD_SITE;
    cmd.mul_op = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.in_range) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_FIN;
        end else if (stat.action == mpsu_pkg::ACT_LOAD) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_FIN;
        end else if (stat.action == mpsu_pkg::ACT_UPDATE) begin
          state_nxt = S_RD1;
        end else begin
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        cmd.res_read = 1'b1;
        state_nxt    = S_FIN;
      end
      S_RD1: begin
        cmd.cap_x0 = 1'b1;
        cmd.rd_sel = mpsu_pkg::RD_LEFT;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        cmd.cap_xl = 1'b1;
        cmd.rd_sel = mpsu_pkg::RD_RIGHT;
        state_nxt  = S_RD3;
      end
      S_RD3: begin
        cmd.cap_xr  = 1'b1;
        cmd.calc_xp = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        cmd.calc_sums = 1'b1;
        op_nxt        = mpsu_pkg::OP_M1;
        state_nxt     = S_MSTART;
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          cmd.mul_cap = 1'b1;
          if (op_r == mpsu_pkg::OP_POT) begin
            state_nxt = S_DS;
          end else begin
            op_nxt    = op_r + 3'd1;
            state_nxt = S_MSTART;
          end
        end
      end
      S_DS: begin
        cmd.calc_ds = 1'b1;
        state_nxt   = S_IDX;
      end
      S_IDX: begin
        cmd.calc_idx = 1'b1;
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= mpsu_pkg::OP_M1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/metropolis_path_site_update.sv]
// Channel  Dir  Payload                                         Transfer
// in_ch    in   action, site, load_value, proposal_noise,       valid & ready
//               accept_noise
// out_ch   out  site_value, accepted, accept_count              valid & ready
// cfg_*    in   cfg_index, cfg_data                             cfg_we
//
// Load and out-of-range items go from decode to the output stage; a read item
// first does one path read. An update makes three path reads from the one read
// port of the path RAM, then eight Q.24 products in sequence on the shared 62x62
// multiplier, which uses one 32x32 partial product per cycle.
// Synchronous active-low reset clears control, counter and configuration; the
// path RAM holds no reset value. A finished result waits in the output register
// while the next item is taken; the sequencer stalls only at the end of an item.
`default_nettype none
module metropolis_path_site_update (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mpsu_in_if.sink          in_ch,
  mpsu_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  mpsu_pkg::dp_cmd_t  cmd;
  mpsu_pkg::dp_stat_t stat;

  mpsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpsu_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_action         (in_ch.action),
    .in_site           (in_ch.site),
    .in_load_value     (in_ch.load_value),
    .in_proposal_noise (in_ch.proposal_noise),
    .in_accept_noise   (in_ch.accept_noise),
    .out_site_value    (out_ch.site_value),
    .out_accepted      (out_ch.accepted),
    .out_accept_count  (out_ch.accept_count)
  );

endmodule
`default_nettype wire

[dv/metropolis_path_site_update_test.sv]
`timescale 1ns / 1ps

module metropolis_path_site_update_test;
  import mpsu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint SAT_Q = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]         action;
    logic [6:0]         site;
    logic signed [31:0] load_value;
    logic signed [15:0] proposal_noise;
    logic [15:0]        accept_noise;
  } site_item_t;

  typedef struct {
    logic signed [31:0] site_value;
    logic               accepted;
    logic [7:0]         accept_count;
  } site_result_t;

  // Predicts each site update and keeps the pending results in order
  class site_update_predictor;
    logic signed [31:0] path[MAX_SITES];
    bit [7:0]           counter;
    bit [7:0]           sites;
    bit [31:0]          spacing, half_inv, quartic, width;
    bit [16:0]          boltz_tab[EXP_TABLE_ENTRIES];
    site_result_t       pending[$];
    int                 errors;

    function new();
      logic [127:0] h, term, sum, v;
      counter  = 0;
      sites    = 100;
      spacing  = 32'd1677722;
      half_inv = 32'd83886080;
      quartic  = 0;
      width    = 32'd12582912;
      errors   = 0;
      foreach (path[i]) path[i] = 0;
      // exp(-16k/E) in Q1.16 from a 16-term series of one step ratio
      h    = (128'd16 << 32) / EXP_TABLE_ENTRIES;
      term = 128'd1 << 32;
      sum  = 128'd1 << 32;
      v    = 128'd1 << 32;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * h) >> 32) / n;
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
        boltz_tab[k] = 17'((v + 128'h8000) >> 16);
        v = (v * sum + 128'h8000_0000) >> 32;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_SITE_COUNT: sites    = data[7:0];
        CFG_SPACING:    spacing  = data;
        CFG_HALF_INV:   half_inv = data;
        CFG_QUARTIC:    quartic  = data;
        CFG_PROP_WIDTH: width    = data;
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > SAT_Q) return SAT_Q;
      if (v < -SAT_Q) return -SAT_Q;
      return v;
    endfunction

    function longint add_sat(longint a, longint b);
      return clip(clip(a) + clip(b));
    endfunction

    // signed Q.24 product, truncated toward zero, saturated
    function longint mul_q24(longint a, longint b);
      longint       ca, cb;
      bit           neg;
      logic [127:0] p;
      ca  = clip(a);
      cb  = clip(b);
      neg = (a < 0) != (b < 0);
      p   = (128'(ca < 0 ? -ca : ca) * 128'(cb < 0 ? -cb : cb)) >> 24;
      if (p > 128'(SAT_Q)) p = 128'(SAT_Q);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void note_item(site_item_t it);
      int           n, li, ri;
      longint       x0, xl, xr, prod, step, xp, d, kin, p2, p4, pot, ds;
      site_result_t res;
      n = sites;
      if (n < 2) n = 2;
      if (n > MAX_SITES) n = MAX_SITES;
      res.site_value = 0;
      res.accepted   = 0;
      if (it.site < n) begin
        if (it.action == ACT_LOAD) begin
          path[it.site] = it.load_value;
        end else if (it.action == ACT_UPDATE) begin
          li   = (it.site == 0) ? n - 1 : it.site - 1;
          ri   = (it.site + 1 == n) ? 0 : it.site + 1;
          x0   = path[it.site];
          xl   = path[li];
          xr   = path[ri];
          prod = longint'(it.proposal_noise) * longint'(width);
          step = prod >>> 15;
          xp   = x0 + step;
          if (xp > 64'sd2147483647) xp = 64'sd2147483647;
          if (xp < -64'sd2147483648) xp = -64'sd2147483648;
          d    = xp - x0;
          kin  = mul_q24(longint'(half_inv), mul_q24(2 * d, xp + x0 - xl - xr));
          p2   = mul_q24(d, xp + x0);
          p4   = mul_q24(p2, add_sat(mul_q24(xp, xp), mul_q24(x0, x0)));
          pot  = mul_q24(longint'(spacing),
                         add_sat(p2 / 2, mul_q24(longint'(quartic), p4)));
          ds   = add_sat(kin, pot);
          if (ds <= 0) res.accepted = 1;
          else if (ds < (64'sd16 << 24)) begin
            if ({1'b0, it.accept_noise} < boltz_tab[ds >>> 20]) res.accepted = 1;
          end
          if (it.site == 0) counter = 0;
          if (res.accepted) begin
            path[it.site] = xp[31:0];
            if (counter < 255) counter++;
          end
        end
        res.site_value = path[it.site];
      end
      res.accept_count = counter;
      pending.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(site_result_t got);
      site_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%0d", got.site_value));
      end else begin
        exp_r = pending.pop_front();
        if (got.site_value !== exp_r.site_value)
          report($sformatf("site_value %0d, predicted %0d", got.site_value, exp_r.site_value));
        if (got.accepted !== exp_r.accepted)
          report($sformatf("accepted %0b, predicted %0b", got.accepted, exp_r.accepted));
        if (got.accept_count !== exp_r.accept_count)
          report($sformatf("accept_count %0d, predicted %0d",
                           got.accept_count, exp_r.accept_count));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  mpsu_in_if  in_ch ();
  mpsu_out_if out_ch ();

  metropolis_path_site_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  site_update_predictor model = new();
  bit   loaded[MAX_SITES];
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  int   quiet_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver: check each result transfer, random stalls, long hold, watchdog
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      model.check_result('{out_ch.site_value, out_ch.accepted, out_ch.accept_count});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("metropolis_path_site_update: mismatch");
      $finish;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic site_item_t mk(logic [1:0] a, logic [6:0] s, logic [31:0] v,
                                    logic [15:0] pn, logic [15:0] an);
    site_item_t it;
    it.action = a; it.site = s; it.load_value = v;
    it.proposal_noise = pn; it.accept_noise = an;
    return it;
  endfunction

  // one input transfer; the predictor sees it when it is accepted
  task automatic send(site_item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= it.action;
    in_ch.site           <= it.site;
    in_ch.load_value     <= it.load_value;
    in_ch.proposal_noise <= it.proposal_noise;
    in_ch.accept_noise   <= it.accept_noise;
    do @(posedge clk); while (!in_ch.ready);
    model.note_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] v[5]);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= v[i];
      model.write_reg(3'(i), v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] position();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic site_item_t random_item();
    int         n, s, li, ri, r;
    site_item_t it;
    n = model.sites;
    if (n < 2) n = 2;
    if (n > MAX_SITES) n = MAX_SITES;
    it = mk(ACT_READ, 0, position(), 16'($urandom), 16'($urandom));
    if (n < MAX_SITES && $urandom_range(99) < 5) begin
      // beyond the wrap point: no effect
      it.action = 2'($urandom_range(3));
      it.site   = 7'($urandom_range(n, MAX_SITES - 1));
      return it;
    end
    s  = $urandom_range(n - 1);
    li = (s == 0) ? n - 1 : s - 1;
    ri = (s + 1 == n) ? 0 : s + 1;
    r  = $urandom_range(99);
    it.site = 7'(s);
    if (r < 20) it.action = ACT_LOAD;
    else if (r < 80) it.action = ACT_UPDATE;
    else if (r < 90) it.action = ACT_READ;
    else it.action = 2'd3;
    if (it.action == ACT_UPDATE && !(loaded[s] && loaded[li] && loaded[ri]))
      it.action = ACT_LOAD;
    if (it.action != ACT_UPDATE && it.action != ACT_LOAD && !loaded[s])
      it.action = ACT_LOAD;
    if (it.action == ACT_LOAD) loaded[s] = 1;
    return it;
  endfunction

  function automatic logic [31:0] pick(int mode, logic [31:0] lim);
    case (mode)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  initial begin
    site_item_t  dir[$];
    logic [31:0] regs[5];
    int          n;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SITE_COUNT;
    cfg_data       = 0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_LOAD;
    in_ch.site     = 0;
    in_ch.load_value     = 0;
    in_ch.proposal_noise = 0;
    in_ch.accept_noise   = 0;
    out_ch.ready   = 1'b0;
    hold_cycles    = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 48;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, wrap neighbors, counter restart, out-of-range sites
    dir.push_back(mk(ACT_LOAD, 0, 32'h0100_0000, 0, 0));
    dir.push_back(mk(ACT_LOAD, 1, 32'h7FFF_FFFF, 0, 0));
    dir.push_back(mk(ACT_LOAD, 2, 32'h8000_0000, 0, 0));
    dir.push_back(mk(ACT_LOAD, 3, 32'h0, 0, 0));
    dir.push_back(mk(ACT_LOAD, 4, 32'hFF80_0000, 0, 0));
    dir.push_back(mk(ACT_LOAD, 97, 32'h0040_0000, 0, 0));
    dir.push_back(mk(ACT_LOAD, 98, 32'hFE00_0000, 0, 0));
    dir.push_back(mk(ACT_LOAD, 99, 32'h0080_0000, 0, 0));
    dir.push_back(mk(ACT_UPDATE, 1, 0, 16'h7FFF, 16'h0000));
    dir.push_back(mk(ACT_UPDATE, 2, 0, 16'h8000, 16'hFFFF));
    dir.push_back(mk(ACT_UPDATE, 0, 0, 16'h0000, 16'h0000));
    dir.push_back(mk(ACT_UPDATE, 99, 0, 16'd1000, 16'hFFFF));
    dir.push_back(mk(ACT_UPDATE, 3, 0, 16'hFFFB, 16'h0000));
    dir.push_back(mk(ACT_UPDATE, 98, 0, 16'd20000, 16'd30000));
    dir.push_back(mk(ACT_UPDATE, 3, 0, 16'd300, 16'h8000));
    dir.push_back(mk(ACT_READ, 1, 0, 0, 0));
    dir.push_back(mk(2'd3, 2, 0, 0, 0));
    dir.push_back(mk(ACT_READ, 0, 0, 0, 0));
    dir.push_back(mk(ACT_LOAD, 100, 32'h1234_5678, 0, 0));
    dir.push_back(mk(ACT_READ, 127, 0, 0, 0));
    dir.push_back(mk(ACT_UPDATE, 110, 0, 16'h7FFF, 0));
    dir.push_back(mk(2'd3, 127, 0, 0, 0));
    dir.push_back(mk(ACT_UPDATE, 0, 0, 16'h8000, 16'h0000));
    foreach (dir[i]) begin
      if (dir[i].action == ACT_LOAD && dir[i].site < 100) loaded[dir[i].site] = 1;
      send(dir[i]);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: regs = '{8'd2, 32'd1677722, 32'd83886080, 32'd0, 32'd12582912};
        1: regs = '{8'd128, pick(3, 32'h0200_0000), pick(3, 32'h1000_0000),
                   pick(3, 32'h0200_0000), pick(3, 32'h0200_0000)};
        2: regs = '{8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};
        3: regs = '{8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        4: regs = '{$urandom_range(3, 127), pick(3, 32'h0200_0000),
                   pick(3, 32'h1000_0000), pick(3, 32'h0100_0000), pick(3, 32'h0200_0000)};
        5: regs = '{8'd1, pick(2, 0), pick(2, 0), pick(2, 0), pick(2, 0)};
        6: regs = '{8'd4, pick(3, 32'h0200_0000), pick(3, 32'h0800_0000),
                   pick(3, 32'h0040_0000), pick(3, 32'h0100_0000)};
        default: regs = '{$urandom_range(2, 255), pick(3, 32'h0200_0000),
                          pick(3, 32'h1000_0000), 32'hFFFF_FFFF, pick(3, 32'h0080_0000)};
      endcase
      set_regs(regs);
      send_idle_pct = (p < 3) ? 13 : (p < 6) ? 48 : 0;
      recv_idle_pct = (p < 3) ? 48 : (p < 6) ? 13 : 0;
      // long receiver hold while items keep coming
      if (p == 2) hold_cycles = 400;
      n = (p == 7) ? 72 : 66;
      for (int i = 0; i < n; i++) begin
        if (p == 4 && i == 30) drain();
        send(random_item());
      end
    end

    in_ch.valid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (model.errors == 0) $display("metropolis_path_site_update: match");
    else $display("metropolis_path_site_update: mismatch");
    $finish;
  end

endmodule
